// ===== hw/rtl/frfcfs_pkg.sv =====
// Shared types, constants and helpers for the FR-FCFS request scheduler.
// No dependencies; every other file in hw/rtl uses it by scoped name.
package frfcfs_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LEAVES      = 1 << IDX_W;
  localparam int unsigned LEVELS      = IDX_W;
  localparam int unsigned CNT_W       = $clog2(LEVELS + 1);

  // Address decode
  localparam int unsigned NUM_BANKS = 8;
  localparam int unsigned BANK_W    = 3;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned BANK_LSB  = 6;
  localparam int unsigned ROW_LSB   = 13;

  localparam logic [4:0] LAT_HIT  = 5'd10;
  localparam logic [4:0] LAT_MISS = 5'd30;

  // Item kinds
  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // One queued request as held in a cell
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  req_type;
    logic [31:0] stamp;
    logic        hit;     // row matches its bank's open row
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic               load;   // enqueue into the cell at index count
    logic               serve;  // collapse behind sel and refresh hit flags
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   sel;
    logic [BANK_W-1:0]  bank;
    logic [ROW_W-1:0]   row;
    entry_t             ent;
  } cmd_t;

  // Partial result of the oldest-entry search
  typedef struct packed {
    logic             any_v;
    logic [31:0]      any_stamp;
    logic [IDX_W-1:0] any_idx;
    logic             hit_v;
    logic [31:0]      hit_stamp;
    logic [IDX_W-1:0] hit_idx;
  } node_t;

  function automatic logic [BANK_W-1:0] bank_of(input logic [31:0] a);
    return a[BANK_LSB +: BANK_W];
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [31:0] a);
    return a[ROW_LSB +: ROW_W];
  endfunction

  // Left child holds the lower indices, so it wins ties.
  function automatic node_t merge(input node_t l, input node_t r);
    node_t m;
    m = r;
    if (l.any_v && (!r.any_v || (l.any_stamp <= r.any_stamp))) begin
      m.any_v     = l.any_v;
      m.any_stamp = l.any_stamp;
      m.any_idx   = l.any_idx;
    end
    if (l.hit_v && (!r.hit_v || (l.hit_stamp <= r.hit_stamp))) begin
      m.hit_v     = l.hit_v;
      m.hit_stamp = l.hit_stamp;
      m.hit_idx   = l.hit_idx;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/frfcfs_cell.sv =====
// One queue slot of the scheduler: holds a request and shifts toward the head.
// Depends on frfcfs_pkg.
module frfcfs_cell (
  input  logic                            clk_i,
  input  logic [frfcfs_pkg::IDX_W-1:0]    idx_i,
  input  frfcfs_pkg::cmd_t                cmd_i,
  input  frfcfs_pkg::entry_t              nbr_i,
  output frfcfs_pkg::entry_t              ent_o
);

  frfcfs_pkg::entry_t ent_q, ent_d, src;

  always_comb begin
    src   = ent_q;
    ent_d = ent_q;
    if (cmd_i.serve && (idx_i >= cmd_i.sel)) begin
      src = nbr_i;
    end
    if (cmd_i.load && (frfcfs_pkg::COUNT_W'(idx_i) == cmd_i.count)) begin
      ent_d = cmd_i.ent;
    end else if (cmd_i.serve) begin
      ent_d = src;
      // refresh the hit flag for the bank whose open row changes
      if (frfcfs_pkg::bank_of(src.addr) == cmd_i.bank) begin
        ent_d.hit = (frfcfs_pkg::row_of(src.addr) == cmd_i.row);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== hw/rtl/frfcfs_min_tree.sv =====
// Registered comparison tree: finds the oldest pending entry and the oldest
// row-hit entry, one tree level per cycle. Depends on frfcfs_pkg.
module frfcfs_min_tree (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frfcfs_pkg::node_t   leaf_i [frfcfs_pkg::LEAVES],
  output frfcfs_pkg::node_t   root_o
);

  // All tree nodes in one row; level l starts at LEAVES - (LEAVES >> l).
  frfcfs_pkg::node_t node_q [frfcfs_pkg::LEAVES-1];

  for (genvar l = 0; l < frfcfs_pkg::LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < (frfcfs_pkg::LEAVES >> (l + 1)); j++) begin : g_node
      frfcfs_pkg::node_t node_d;
      if (l == 0) begin : g_first
        assign node_d = frfcfs_pkg::merge(leaf_i[2*j], leaf_i[2*j+1]);
      end else begin : g_rest
        assign node_d = frfcfs_pkg::merge(
          node_q[(frfcfs_pkg::LEAVES - (frfcfs_pkg::LEAVES >> (l - 1))) + 2*j],
          node_q[(frfcfs_pkg::LEAVES - (frfcfs_pkg::LEAVES >> (l - 1))) + 2*j + 1]);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_q[(frfcfs_pkg::LEAVES - (frfcfs_pkg::LEAVES >> l)) + j] <= '0;
        end else begin
          node_q[(frfcfs_pkg::LEAVES - (frfcfs_pkg::LEAVES >> l)) + j] <= node_d;
        end
      end
    end
  end

  assign root_o = node_q[frfcfs_pkg::LEAVES-2];

endmodule

// ===== hw/rtl/frfcfs_dram_scheduler.sv =====
// Top level of the FR-FCFS DRAM request scheduler.
// Depends on frfcfs_pkg, frfcfs_cell and frfcfs_min_tree.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item: kind_i
//   selects enqueue (store req_type_i, addr_i, data_i at the queue tail) or
//   schedule (serve one pending request). Every item yields exactly one
//   result beat on the output channel (out_valid_o/out_ready_i).
//   The queue is a chain of cells; serving a request collapses the gap by
//   shifting every cell behind it one place toward the head at once.
//   A schedule item finds the oldest row-hit entry and the oldest entry via
//   a registered comparison tree of log2(depth) levels (5 for 32 entries).
// Flow:
//   Enqueue, dropped enqueue and schedule on an empty queue commit without
//   waiting on the tree; a schedule on a non-empty queue first counts down
//   until the tree has settled. The block takes one item at a time; the next
//   input beat is taken the cycle after a result is registered, even while
//   that result waits.
// Reset:
//   rst_ni clears the queue count, open rows, served count and the output
//   valid; queue payload holds no reset value and is never read unwritten.
// Stall:
//   While out_ready_i is low the result is held; a finished item waits for
//   the output register before it updates any state.
module frfcfs_dram_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] addr_i,
  input  logic [31:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  slot_index_o,
  output logic        row_hit_o,
  output logic [4:0]  latency_o,
  output logic [31:0] served_addr_o,
  output logic [31:0] served_data_o,
  output logic [1:0]  served_type_o,
  output logic [5:0]  queue_count_o
);

  // Control state
  frfcfs_pkg::state_e                 state_q, state_d;
  logic [frfcfs_pkg::CNT_W-1:0]       wait_q, wait_d;
  logic [frfcfs_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [31:0]                        served_q, served_d;
  logic [frfcfs_pkg::ROW_W-1:0]       open_row_q [frfcfs_pkg::NUM_BANKS];

  // Captured item
  logic        kind_q;
  logic [1:0]  type_q;
  logic [31:0] addr_q, data_q;

  // Output register
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [4:0]  slot_q, slot_d;
  logic        hit_q, hit_d;
  logic [4:0]  lat_q, lat_d;
  logic [31:0] saddr_q, saddr_d, sdata_q, sdata_d;
  logic [1:0]  stype_q, stype_d;
  logic [5:0]  qcnt_q, qcnt_d;

  logic in_fire, out_free, commit, need_tree, done;
  logic [31:0] count_ext, sel_ext;
  logic [frfcfs_pkg::IDX_W-1:0] sel;

  frfcfs_pkg::cmd_t   cmd;
  frfcfs_pkg::entry_t ents [frfcfs_pkg::QUEUE_DEPTH];
  frfcfs_pkg::entry_t sel_ent;
  frfcfs_pkg::node_t  leaves [frfcfs_pkg::LEAVES];
  frfcfs_pkg::node_t  root;

  assign in_ready_o = (state_q == frfcfs_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Cell chain: each cell takes its upper neighbor on a collapse.
  for (genvar i = 0; i < frfcfs_pkg::QUEUE_DEPTH; i++) begin : g_cell
    frfcfs_pkg::entry_t nbr;
    if (i == frfcfs_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign nbr = ents[i];
    end else begin : g_mid
      assign nbr = ents[i+1];
    end
    frfcfs_cell u_cell (
      .clk_i (clk_i),
      .idx_i (frfcfs_pkg::IDX_W'(i)),
      .cmd_i (cmd),
      .nbr_i (nbr),
      .ent_o (ents[i])
    );
  end

  // Tree leaves: only slots below the count take part.
  for (genvar j = 0; j < frfcfs_pkg::LEAVES; j++) begin : g_leaf
    if (j < frfcfs_pkg::QUEUE_DEPTH) begin : g_real
      logic pend;
      assign pend = (frfcfs_pkg::COUNT_W'(j) < count_q);
      assign leaves[j].any_v     = pend;
      assign leaves[j].any_stamp = ents[j].stamp;
      assign leaves[j].any_idx   = frfcfs_pkg::IDX_W'(j);
      assign leaves[j].hit_v     = pend && ents[j].hit;
      assign leaves[j].hit_stamp = ents[j].stamp;
      assign leaves[j].hit_idx   = frfcfs_pkg::IDX_W'(j);
    end else begin : g_pad
      assign leaves[j] = '0;
    end
  end

  frfcfs_min_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .leaf_i (leaves),
    .root_o (root)
  );

  // Row hits win; otherwise serve the oldest entry.
  assign sel     = root.hit_v ? root.hit_idx : root.any_idx;
  assign sel_ent = ents[sel];
  assign sel_ext = 32'(sel);

  // Control and result formation
  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    count_d   = count_q;
    served_d  = served_q;
    need_tree = (kind_q == frfcfs_pkg::KIND_SCHED) && (count_q != '0);
    done      = !need_tree || (wait_q == '0);
    commit    = 1'b0;

    cmd              = '0;
    cmd.count        = count_q;
    cmd.sel          = sel;
    cmd.bank         = frfcfs_pkg::bank_of(sel_ent.addr);
    cmd.row          = frfcfs_pkg::row_of(sel_ent.addr);
    cmd.ent.addr     = addr_q;
    cmd.ent.data     = data_q;
    cmd.ent.req_type = type_q;
    cmd.ent.stamp    = served_q;
    cmd.ent.hit      = (open_row_q[frfcfs_pkg::bank_of(addr_q)] ==
                        frfcfs_pkg::row_of(addr_q));

    status_d = frfcfs_pkg::ST_ENQUEUED;
    slot_d   = '0;
    hit_d    = 1'b0;
    lat_d    = '0;
    saddr_d  = '0;
    sdata_d  = '0;
    stype_d  = '0;

    case (state_q)
      frfcfs_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = frfcfs_pkg::S_EXEC;
          wait_d  = frfcfs_pkg::CNT_W'(frfcfs_pkg::LEVELS - 1);
        end
      end
      frfcfs_pkg::S_EXEC: begin
        // count down until the tree reflects the settled queue
        if (wait_q != '0) begin
          wait_d = wait_q - frfcfs_pkg::CNT_W'(1);
        end
        if (done && out_free) begin
          commit  = 1'b1;
          state_d = frfcfs_pkg::S_IDLE;
          if (kind_q == frfcfs_pkg::KIND_ENQ) begin
            if (count_q == frfcfs_pkg::COUNT_W'(frfcfs_pkg::QUEUE_DEPTH)) begin
              status_d = frfcfs_pkg::ST_DROPPED;
            end else begin
              status_d = frfcfs_pkg::ST_ENQUEUED;
              cmd.load = 1'b1;
              count_d  = count_q + frfcfs_pkg::COUNT_W'(1);
            end
          end else if (!need_tree) begin
            status_d = frfcfs_pkg::ST_EMPTY;
          end else begin
            status_d  = frfcfs_pkg::ST_SERVED;
            cmd.serve = 1'b1;
            count_d   = count_q - frfcfs_pkg::COUNT_W'(1);
            served_d  = served_q + 32'd1;
            slot_d    = sel_ext[4:0];
            hit_d     = root.hit_v;
            lat_d     = root.hit_v ? frfcfs_pkg::LAT_HIT : frfcfs_pkg::LAT_MISS;
            saddr_d   = sel_ent.addr;
            sdata_d   = sel_ent.data;
            stype_d   = sel_ent.req_type;
          end
        end
      end
      default: begin
        state_d = frfcfs_pkg::S_IDLE;
      end
    endcase

    count_ext = 32'(count_d);
    qcnt_d    = count_ext[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frfcfs_pkg::S_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      served_q    <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < frfcfs_pkg::NUM_BANKS; b++) begin
        open_row_q[b] <= '0;
      end
    end else begin
      state_q  <= state_d;
      wait_q   <= wait_d;
      count_q  <= count_d;
      served_q <= served_d;
      if (cmd.serve) begin
        open_row_q[cmd.bank] <= cmd.row;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the item, hold the result until taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      type_q <= req_type_i;
      addr_q <= addr_i;
      data_q <= data_i;
    end
    if (commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      hit_q    <= hit_d;
      lat_q    <= lat_d;
      saddr_q  <= saddr_d;
      sdata_q  <= sdata_d;
      stype_q  <= stype_d;
      qcnt_q   <= qcnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign row_hit_o     = hit_q;
  assign latency_o     = lat_q;
  assign served_addr_o = saddr_q;
  assign served_data_o = sdata_q;
  assign served_type_o = stype_q;
  assign queue_count_o = qcnt_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= frfcfs_pkg::COUNT_W'(frfcfs_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_serve_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.serve |=> (count_q == $past(count_q) - frfcfs_pkg::COUNT_W'(1)))
    else $error("serve did not shrink the queue");

  a_hit_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == frfcfs_pkg::ST_SERVED)) |->
      ((row_hit_o && (latency_o == frfcfs_pkg::LAT_HIT)) ||
       (!row_hit_o && (latency_o == frfcfs_pkg::LAT_MISS))))
    else $error("latency disagrees with row hit");

  a_commit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending beat");

endmodule

// ===== sim/frfcfs_dram_scheduler_tb.sv =====
// Self-checking testbench for frfcfs_dram_scheduler: directed and random beats are
// checked against an in-bench FR-FCFS predictor. Depends on frfcfs_pkg and the RTL.
module frfcfs_dram_scheduler_tb;

  localparam int ITEMS       = 1400;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic        kind;
    logic [1:0]  rtype;
    logic [31:0] addr;
    logic [31:0] data;
  } command_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic        hit;
    logic [4:0]  lat;
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  rtype;
    logic [5:0]  count;
  } response_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        kind_i      = 1'b0;
  logic [1:0]  req_type_i  = '0;
  logic [31:0] addr_i      = '0;
  logic [31:0] data_i      = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [4:0]  slot_index_o;
  logic        row_hit_o;
  logic [4:0]  latency_o;
  logic [31:0] served_addr_o;
  logic [31:0] served_data_o;
  logic [1:0]  served_type_o;
  logic [5:0]  queue_count_o;

  frfcfs_dram_scheduler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .req_type_i   (req_type_i),
    .addr_i       (addr_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .row_hit_o    (row_hit_o),
    .latency_o    (latency_o),
    .served_addr_o(served_addr_o),
    .served_data_o(served_data_o),
    .served_type_o(served_type_o),
    .queue_count_o(queue_count_o)
  );

  always #1 clk_i = ~clk_i;

  command_t  command_q[$];
  response_t outcome_q[$];
  int        total_items = 0;
  int        gen_fill    = 0;
  int        beats_in    = 0;
  int        mismatches  = 0;
  int        stall_cycles = 0;
  logic      in_took     = 1'b0;

  // Predictor state: the pending queue in arrival order, open rows, served count
  logic [31:0]                  q_addr  [frfcfs_pkg::QUEUE_DEPTH];
  logic [31:0]                  q_data  [frfcfs_pkg::QUEUE_DEPTH];
  logic [1:0]                   q_type  [frfcfs_pkg::QUEUE_DEPTH];
  logic [31:0]                  q_stamp [frfcfs_pkg::QUEUE_DEPTH];
  logic [frfcfs_pkg::ROW_W-1:0] row_open[frfcfs_pkg::NUM_BANKS];
  logic [31:0]                  serve_cnt = '0;
  int                           fill      = 0;

  initial begin
    for (int b = 0; b < frfcfs_pkg::NUM_BANKS; b++) row_open[b] = '0;
  end

  // Work out the scheduler's answer to one command and advance the predictor.
  function automatic response_t fr_fcfs_response(command_t c);
    response_t                     r;
    bit                            hit_seen;
    int                            hit_idx;
    int                            old_idx;
    int                            sel;
    logic [31:0]                   hit_st;
    logic [31:0]                   old_st;
    logic [frfcfs_pkg::BANK_W-1:0] bk;
    logic [frfcfs_pkg::ROW_W-1:0]  rw;
    r = '{default: '0};
    hit_seen = 1'b0;
    hit_idx = 0;
    old_idx = 0;
    hit_st = '0;
    old_st = '0;
    if (c.kind == frfcfs_pkg::KIND_ENQ) begin
      if (fill < frfcfs_pkg::QUEUE_DEPTH) begin
        q_addr[fill]  = c.addr;
        q_data[fill]  = c.data;
        q_type[fill]  = c.rtype;
        q_stamp[fill] = serve_cnt;
        fill++;
        r.status = frfcfs_pkg::ST_ENQUEUED;
      end else begin
        r.status = frfcfs_pkg::ST_DROPPED;
      end
      r.count = 6'(fill);
      return r;
    end
    if (fill == 0) begin
      r.status = frfcfs_pkg::ST_EMPTY;
      return r;
    end
    // Oldest row hit first, oldest overall otherwise; strict compare keeps the
    // lowest index on equal stamps.
    for (int i = 0; i < fill; i++) begin
      bk = q_addr[i][frfcfs_pkg::BANK_LSB +: frfcfs_pkg::BANK_W];
      rw = q_addr[i][frfcfs_pkg::ROW_LSB +: frfcfs_pkg::ROW_W];
      if (row_open[bk] == rw && (!hit_seen || q_stamp[i] < hit_st)) begin
        hit_seen = 1'b1;
        hit_idx  = i;
        hit_st   = q_stamp[i];
      end
      if (i == 0 || q_stamp[i] < old_st) begin
        old_idx = i;
        old_st  = q_stamp[i];
      end
    end
    sel = hit_seen ? hit_idx : old_idx;
    row_open[q_addr[sel][frfcfs_pkg::BANK_LSB +: frfcfs_pkg::BANK_W]] =
      q_addr[sel][frfcfs_pkg::ROW_LSB +: frfcfs_pkg::ROW_W];
    serve_cnt++;
    r.status = frfcfs_pkg::ST_SERVED;
    r.slot   = 5'(sel);
    r.hit    = hit_seen;
    r.lat    = hit_seen ? frfcfs_pkg::LAT_HIT : frfcfs_pkg::LAT_MISS;
    r.addr   = q_addr[sel];
    r.data   = q_data[sel];
    r.rtype  = q_type[sel];
    // Close the gap behind the served entry
    for (int i = sel; i + 1 < fill; i++) begin
      q_addr[i]  = q_addr[i + 1];
      q_data[i]  = q_data[i + 1];
      q_type[i]  = q_type[i + 1];
      q_stamp[i] = q_stamp[i + 1];
    end
    fill--;
    r.count = 6'(fill);
    return r;
  endfunction

  // Rows come mostly from a small pool so that open-row hits are frequent.
  function automatic logic [frfcfs_pkg::ROW_W-1:0] pick_row();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4:    return frfcfs_pkg::ROW_W'(1);
      5, 6:    return '1;
      7:       return frfcfs_pkg::ROW_W'(10'h155);
      default: return frfcfs_pkg::ROW_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] addr_at(int bank, logic [frfcfs_pkg::ROW_W-1:0] row);
    logic [31:0] a;
    a = $urandom;
    a[frfcfs_pkg::BANK_LSB +: frfcfs_pkg::BANK_W] = frfcfs_pkg::BANK_W'(bank);
    a[frfcfs_pkg::ROW_LSB +: frfcfs_pkg::ROW_W]   = row;
    return a;
  endfunction

  task automatic push_cmd(logic kind, logic [1:0] rtype, logic [31:0] addr,
                          logic [31:0] data);
    command_t c;
    c = '{kind: kind, rtype: rtype, addr: addr, data: data};
    command_q.push_back(c);
    if (kind == frfcfs_pkg::KIND_ENQ && gen_fill < frfcfs_pkg::QUEUE_DEPTH) gen_fill++;
    if (kind == frfcfs_pkg::KIND_SCHED && gen_fill > 0) gen_fill--;
  endtask

  task automatic enq_random();
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'($urandom_range(3)),
             addr_at($urandom_range(7), pick_row()), $urandom);
  endtask

  // Payload of a schedule beat is ignored; randomize it anyway.
  task automatic sched_one();
    push_cmd(frfcfs_pkg::KIND_SCHED, 2'($urandom_range(3)), $urandom, $urandom);
  endtask

  function automatic int phase_now();
    if (beats_in * 3 < total_items) return 0;
    if (beats_in * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  // Sender: hold a beat until taken, then advance or idle
  always @(negedge clk_i) begin : drive
    command_t nxt;
    int       idle_pct;
    if (rst_ni && (!in_valid_i || in_took)) begin
      idle_pct = (phase_now() == 0) ? 9 : (phase_now() == 1) ? 78 : 0;
      if (command_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = command_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= nxt.kind;
        req_type_i <= nxt.rtype;
        addr_i     <= nxt.addr;
        data_i     <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk_i) begin : accept
    int idle_pct;
    idle_pct = (phase_now() == 0) ? 78 : (phase_now() == 1) ? 9 : 0;
    out_ready_i <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  // Monitor: predict on every input beat, check every result beat
  always @(posedge clk_i) begin : watch
    command_t  c;
    response_t e;
    response_t got;
    bit        took_out;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took  <= in_valid_i && in_ready_o;
      took_out = out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        c = '{kind: kind_i, rtype: req_type_i, addr: addr_i, data: data_i};
        outcome_q.push_back(fr_fcfs_response(c));
        beats_in++;
      end
      if (took_out) begin
        got = '{status: status_o, slot: slot_index_o, hit: row_hit_o, lat: latency_o,
                addr: served_addr_o, data: served_data_o, rtype: served_type_o,
                count: queue_count_o};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: st=%0d slot=%0d addr=%h cnt=%0d",
                     got.status, got.slot, got.addr, got.count);
        end else begin
          e = outcome_q.pop_front();
          if (got.status !== e.status || got.slot !== e.slot || got.hit !== e.hit ||
              got.lat !== e.lat || got.addr !== e.addr || got.data !== e.data ||
              got.rtype !== e.rtype || got.count !== e.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: exp st=%0d sl=%0d hit=%0d lat=%0d a=%h d=%h ty=%0d cnt=%0d",
                       e.status, e.slot, e.hit, e.lat, e.addr, e.data, e.rtype, e.count);
              $display("          got st=%0d sl=%0d hit=%0d lat=%0d a=%h d=%h ty=%0d cnt=%0d",
                       got.status, got.slot, got.hit, got.lat, got.addr, got.data,
                       got.rtype, got.count);
            end
          end
        end
      end
      // Watchdog on cycles with no beat on either channel
      if ((in_valid_i && in_ready_o) || took_out) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int m;
    // Directed: empty queue, field extremes, every type, hit versus miss
    sched_one();
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd0, 32'h0000_0000, 32'h0000_0000);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd1, addr_at(7, frfcfs_pkg::ROW_W'(5)), $urandom);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd2, addr_at(2, '0), $urandom);
    sched_one();
    sched_one();
    sched_one();
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd1, addr_at(7, '1), $urandom);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd2, addr_at(4, frfcfs_pkg::ROW_W'(9)), $urandom);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd3, addr_at(4, frfcfs_pkg::ROW_W'(9)), $urandom);
    sched_one();
    sched_one();
    sched_one();
    sched_one();
    sched_one();
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd0, addr_at(0, frfcfs_pkg::ROW_W'(1)), 32'hA5A5_5A5A);
    push_cmd(frfcfs_pkg::KIND_ENQ, 2'd1, addr_at(0, '0), 32'h5A5A_A5A5);
    sched_one();
    sched_one();
    // Random: fill bursts up to full and past it, drains down to empty and past
    // it, and mixed traffic in between
    while (command_q.size() < ITEMS) begin
      m = $urandom_range(9);
      if (m < 3) begin
        while (gen_fill < frfcfs_pkg::QUEUE_DEPTH) enq_random();
        repeat ($urandom_range(3, 1)) enq_random();
      end else if (m < 6) begin
        while (gen_fill > 0) sched_one();
        repeat ($urandom_range(2, 1)) sched_one();
      end else begin
        repeat ($urandom_range(60, 20)) begin
          if ($urandom_range(99) < 55) enq_random();
          else sched_one();
        end
      end
    end
    total_items = command_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() > 0 || in_valid_i || outcome_q.size() > 0) @(posedge clk_i);
    // Let any stray result surface
    repeat (12) @(posedge clk_i);
    mismatches += outcome_q.size();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
